### design/qco_pkg.sv
// ----------------------------------------------------------------------------
// qco_pkg: shared types and constants of the quadrilateral corner offset block
// Holds the fixed-point widths, pipeline depths and the corner/edge tables.
// ----------------------------------------------------------------------------
package qco_pkg;

    localparam int CoordW   = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int SqW      = 2 * DiffW;
    localparam int SqShift  = 30;
    localparam int RadW     = 64;
    localparam int RootW    = RadW / 2;
    localparam int RemW     = RootW + 2;
    localparam int DivSteps = CoordW + 1;
    localparam int DivPre   = 31 - DivSteps;
    localparam int UnitW    = DivSteps + 1;
    localparam int ProdW    = UnitW + CoordW;
    localparam int FracW    = 16;
    localparam int TW       = ProdW + 3;
    localparam int UvLat    = RootW + DivSteps + 3;
    localparam int NumEdges = 4;
    localparam int NumCoord = 8;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [UnitW-1:0]  t_unit;

    // Edges: 0 = LT to RT, 1 = LT to BL, 2 = RT to BR, 3 = BL to BR.
    // Corners: 0 = LT, 1 = RT, 2 = BL, 3 = BR.
    localparam int EdgeFrom [NumEdges] = '{0, 0, 1, 2};
    localparam int EdgeTo   [NumEdges] = '{1, 2, 3, 3};
    localparam int HorEdge  [4]        = '{0, 0, 3, 3};
    localparam int HorNeg   [4]        = '{0, 1, 0, 1};
    localparam int VerEdge  [4]        = '{1, 2, 1, 2};
    localparam int VerNeg   [4]        = '{0, 0, 1, 1};

endpackage

### design/qco_unit_vec.sv
// ----------------------------------------------------------------------------
// qco_unit_vec: pipelined unit vector of one edge
// Squares and sums the edge difference, takes a one-bit-per-stage square root
// and two one-bit-per-stage divisions, giving Q2.16 components and a flag for
// a zero-length edge.
// ----------------------------------------------------------------------------
module qco_unit_vec (
    input  logic           i_clk,
    input  logic           i_en,
    input  qco_pkg::t_diff i_dx,
    input  qco_pkg::t_diff i_dy,
    output qco_pkg::t_unit o_ux,
    output qco_pkg::t_unit o_uy,
    output logic           o_zero
);
    import qco_pkg::*;

    logic [SqW-1:0]   r_sqx;
    logic [SqW-1:0]   r_sqy;
    t_diff            r_dx1;
    t_diff            r_dy1;

    logic [SqW-1:0]   r_s    [RootW+1];
    logic [RemW-1:0]  r_rem  [RootW+1];
    logic [RootW-1:0] r_root [RootW+1];
    t_diff            r_qdx  [RootW+1];
    t_diff            r_qdy  [RootW+1];
    logic             r_qz   [RootW+1];

    logic [RootW-1:0] r_len  [DivSteps+1];
    logic [RootW-1:0] r_remx [DivSteps+1];
    logic [RootW-1:0] r_remy [DivSteps+1];
    logic [DivSteps-1:0] r_qx [DivSteps+1];
    logic [DivSteps-1:0] r_qy [DivSteps+1];
    logic             r_negx [DivSteps+1];
    logic             r_negy [DivSteps+1];
    logic             r_dz   [DivSteps+1];

    t_unit            r_ux;
    t_unit            r_uy;
    logic             r_zero;

    logic [DiffW-1:0] w_ax;
    logic [DiffW-1:0] w_ay;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= unsigned'(SqW'(i_dx) * SqW'(i_dx));
            r_sqy <= unsigned'(SqW'(i_dy) * SqW'(i_dy));
            r_dx1 <= i_dx;
            r_dy1 <= i_dy;
            r_s[0]    <= r_sqx + r_sqy;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_qdx[0]  <= r_dx1;
            r_qdy[0]  <= r_dy1;
            r_qz[0]   <= (r_sqx + r_sqy) == '0;
        end
    end

    for (genvar k = 0; k < RootW; k++) begin : g_sqrt
        logic [RadW-1:0]   w_rad;
        logic [RemW+1:0]   w_cur;
        logic [RemW+1:0]   w_trial;
        logic              w_ge;
        assign w_rad   = {r_s[k], {SqShift{1'b0}}};
        assign w_cur   = {r_rem[k], w_rad[RadW-1-2*k -: 2]};
        assign w_trial = {2'b00, r_root[k], 2'b01};
        assign w_ge    = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? RemW'(w_cur - w_trial) : RemW'(w_cur);
                r_root[k+1] <= {r_root[k][RootW-2:0], w_ge};
                r_s[k+1]    <= r_s[k];
                r_qdx[k+1]  <= r_qdx[k];
                r_qdy[k+1]  <= r_qdy[k];
                r_qz[k+1]   <= r_qz[k];
            end
        end
    end

    assign w_ax = r_qdx[RootW][DiffW-1] ? DiffW'(-r_qdx[RootW]) : DiffW'(r_qdx[RootW]);
    assign w_ay = r_qdy[RootW][DiffW-1] ? DiffW'(-r_qdy[RootW]) : DiffW'(r_qdy[RootW]);

    always_comb begin
        r_len[0]  = r_root[RootW];
        r_remx[0] = RootW'({w_ax, {DivPre{1'b0}}});
        r_remy[0] = RootW'({w_ay, {DivPre{1'b0}}});
        r_qx[0]   = '0;
        r_qy[0]   = '0;
        r_negx[0] = r_qdx[RootW][DiffW-1];
        r_negy[0] = r_qdy[RootW][DiffW-1];
        r_dz[0]   = r_qz[RootW];
    end

    for (genvar j = 0; j < DivSteps; j++) begin : g_div
        logic [RootW:0] w_tx;
        logic [RootW:0] w_ty;
        logic [RootW:0] w_d;
        logic           w_gx;
        logic           w_gy;
        assign w_tx = {r_remx[j], 1'b0};
        assign w_ty = {r_remy[j], 1'b0};
        assign w_d  = {1'b0, r_len[j]};
        assign w_gx = w_tx >= w_d;
        assign w_gy = w_ty >= w_d;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_remx[j+1] <= w_gx ? RootW'(w_tx - w_d) : RootW'(w_tx);
                r_remy[j+1] <= w_gy ? RootW'(w_ty - w_d) : RootW'(w_ty);
                r_qx[j+1]   <= {r_qx[j][DivSteps-2:0], w_gx};
                r_qy[j+1]   <= {r_qy[j][DivSteps-2:0], w_gy};
                r_len[j+1]  <= r_len[j];
                r_negx[j+1] <= r_negx[j];
                r_negy[j+1] <= r_negy[j];
                r_dz[j+1]   <= r_dz[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux   <= r_negx[DivSteps] ? -t_unit'({1'b0, r_qx[DivSteps]})
                                       :  t_unit'({1'b0, r_qx[DivSteps]});
            r_uy   <= r_negy[DivSteps] ? -t_unit'({1'b0, r_qy[DivSteps]})
                                       :  t_unit'({1'b0, r_qy[DivSteps]});
            r_zero <= r_dz[DivSteps];
        end
    end

    assign o_ux   = r_ux;
    assign o_uy   = r_uy;
    assign o_zero = r_zero;

endmodule

### design/quad_corner_offset.sv
// ----------------------------------------------------------------------------
// quad_corner_offset: moves the corners of a quadrilateral along its edges
// Each corner moves by shift_along along its horizontal edge and by
// shift_across along its vertical edge, in Q2.16 fixed point, truncated and
// saturated to 16 bits. A zero-length edge returns the corners unchanged.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   four corners, two shifts, inward
// output    out        o_valid / i_ready   four moved corners, degenerate
//
// One item is accepted per cycle while the output is not stalled; the latency is set
// by the 32-stage square root and the 17-stage dividers of the edge unit vectors.
// Reset clears only the valid bits of the stages.
// A stall of the output holds the whole pipeline in place.
// ----------------------------------------------------------------------------
module quad_corner_offset (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qco_pkg::t_coord i_top_left_x,
    input  qco_pkg::t_coord i_top_left_y,
    input  qco_pkg::t_coord i_top_right_x,
    input  qco_pkg::t_coord i_top_right_y,
    input  qco_pkg::t_coord i_bottom_left_x,
    input  qco_pkg::t_coord i_bottom_left_y,
    input  qco_pkg::t_coord i_bottom_right_x,
    input  qco_pkg::t_coord i_bottom_right_y,
    input  qco_pkg::t_coord i_shift_along,
    input  qco_pkg::t_coord i_shift_across,
    input  logic            i_inward,
    output logic            o_valid,
    input  logic            i_ready,
    output qco_pkg::t_coord o_new_top_left_x,
    output qco_pkg::t_coord o_new_top_left_y,
    output qco_pkg::t_coord o_new_top_right_x,
    output qco_pkg::t_coord o_new_top_right_y,
    output qco_pkg::t_coord o_new_bottom_left_x,
    output qco_pkg::t_coord o_new_bottom_left_y,
    output qco_pkg::t_coord o_new_bottom_right_x,
    output qco_pkg::t_coord o_new_bottom_right_y,
    output logic            o_degenerate
);
    import qco_pkg::*;

    localparam int PayN = UvLat + 1;
    localparam logic signed [TW-1:0] SatMax = TW'((2 ** (CoordW - 1)) - 1);
    localparam logic signed [TW-1:0] SatMin = -TW'(2 ** (CoordW - 1));

    logic   w_en;
    t_coord w_in_c [NumCoord];

    t_coord r_c0 [NumCoord];
    t_coord r_sa0;
    t_coord r_sc0;
    logic   r_inw0;
    logic   r_vld0;

    t_diff  r_dx [NumEdges];
    t_diff  r_dy [NumEdges];

    t_coord r_pc   [PayN][NumCoord];
    t_coord r_psa  [PayN];
    t_coord r_psc  [PayN];
    logic   r_pinw [PayN];
    logic   r_pvld [PayN];

    t_unit  w_ux   [NumEdges];
    t_unit  w_uy   [NumEdges];
    logic   w_zero [NumEdges];

    logic signed [ProdW-1:0] r_mh [NumCoord];
    logic signed [ProdW-1:0] r_mv [NumCoord];
    t_coord r_mc [NumCoord];
    logic   r_minw;
    logic   r_mdeg;
    logic   r_mvld;

    logic signed [TW-1:0] r_t [NumCoord];
    t_coord r_sc [NumCoord];
    logic   r_sdeg;
    logic   r_svld;

    t_coord r_o [NumCoord];
    logic   r_odeg;
    logic   r_ovld;

    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    assign w_in_c[0] = i_top_left_x;
    assign w_in_c[1] = i_top_left_y;
    assign w_in_c[2] = i_top_right_x;
    assign w_in_c[3] = i_top_right_y;
    assign w_in_c[4] = i_bottom_left_x;
    assign w_in_c[5] = i_bottom_left_y;
    assign w_in_c[6] = i_bottom_right_x;
    assign w_in_c[7] = i_bottom_right_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_mvld <= 1'b0;
            r_svld <= 1'b0;
            r_ovld <= 1'b0;
            for (int k = 0; k < PayN; k++) begin
                r_pvld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld0    <= i_valid;
            r_pvld[0] <= r_vld0;
            for (int k = 1; k < PayN; k++) begin
                r_pvld[k] <= r_pvld[k-1];
            end
            r_mvld <= r_pvld[PayN-1];
            r_svld <= r_mvld;
            r_ovld <= r_svld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0      <= w_in_c;
            r_sa0     <= i_shift_along;
            r_sc0     <= i_shift_across;
            r_inw0    <= i_inward;
            r_pc[0]   <= r_c0;
            r_psa[0]  <= r_sa0;
            r_psc[0]  <= r_sc0;
            r_pinw[0] <= r_inw0;
            for (int k = 1; k < PayN; k++) begin
                r_pc[k]   <= r_pc[k-1];
                r_psa[k]  <= r_psa[k-1];
                r_psc[k]  <= r_psc[k-1];
                r_pinw[k] <= r_pinw[k-1];
            end
        end
    end

    for (genvar e = 0; e < NumEdges; e++) begin : g_edge
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dx[e] <= t_diff'(r_c0[2*EdgeTo[e]]) - t_diff'(r_c0[2*EdgeFrom[e]]);
                r_dy[e] <= t_diff'(r_c0[2*EdgeTo[e]+1]) - t_diff'(r_c0[2*EdgeFrom[e]+1]);
            end
        end

        qco_unit_vec u_unit (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_dx   (r_dx[e]),
            .i_dy   (r_dy[e]),
            .o_ux   (w_ux[e]),
            .o_uy   (w_uy[e]),
            .o_zero (w_zero[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mc   <= r_pc[PayN-1];
            r_minw <= r_pinw[PayN-1];
            r_mdeg <= w_zero[0] || w_zero[1] || w_zero[2] || w_zero[3];
            r_sc   <= r_mc;
            r_sdeg <= r_mdeg;
            r_odeg <= r_sdeg;
        end
    end

    for (genvar j = 0; j < NumCoord; j++) begin : g_coord
        localparam int Cn = j / 2;
        localparam int Ax = j % 2;

        t_unit                w_uh;
        t_unit                w_uv;
        logic signed [TW-1:0] w_base;
        logic signed [TW-1:0] w_th;
        logic signed [TW-1:0] w_tv;
        logic                 w_addh;
        logic                 w_addv;
        logic signed [TW-1:0] w_q;
        logic signed [TW-1:0] w_qt;
        t_coord               w_sat;

        assign w_uh = (Ax == 1) ? w_uy[HorEdge[Cn]] : w_ux[HorEdge[Cn]];
        assign w_uv = (Ax == 1) ? w_uy[VerEdge[Cn]] : w_ux[VerEdge[Cn]];

        assign w_base = TW'(r_mc[j]) <<< FracW;
        assign w_th   = TW'(r_mh[j]);
        assign w_tv   = TW'(r_mv[j]);
        assign w_addh = r_minw ^ (HorNeg[Cn] == 1);
        assign w_addv = r_minw ^ (VerNeg[Cn] == 1);

        assign w_q  = r_t[j] >>> FracW;
        assign w_qt = (r_t[j][TW-1] && (r_t[j][FracW-1:0] != '0)) ? w_q + TW'(1) : w_q;

        always_comb begin
            if (w_qt > SatMax) begin
                w_sat = SatMax[CoordW-1:0];
            end else if (w_qt < SatMin) begin
                w_sat = SatMin[CoordW-1:0];
            end else begin
                w_sat = w_qt[CoordW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mh[j] <= ProdW'(w_uh) * ProdW'(r_psa[PayN-1]);
                r_mv[j] <= ProdW'(w_uv) * ProdW'(r_psc[PayN-1]);
                r_t[j]  <= w_base + (w_addh ? w_th : -w_th) + (w_addv ? w_tv : -w_tv);
                r_o[j]  <= r_sdeg ? r_sc[j] : w_sat;
            end
        end
    end

    assign o_valid              = r_ovld;
    assign o_degenerate         = r_odeg;
    assign o_new_top_left_x     = r_o[0];
    assign o_new_top_left_y     = r_o[1];
    assign o_new_top_right_x    = r_o[2];
    assign o_new_top_right_y    = r_o[3];
    assign o_new_bottom_left_x  = r_o[4];
    assign o_new_bottom_left_y  = r_o[5];
    assign o_new_bottom_right_x = r_o[6];
    assign o_new_bottom_right_y = r_o[7];

endmodule

### dv/tb_quad_corner_offset.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quad_corner_offset: self-checking testbench of the corner offset block
// A directed table and then random quadrilaterals are driven through the
// valid/ready input while the output is stalled at random. Every item but the
// copy_back table rows is predicted in fixed point and checked field by field in order.
// ----------------------------------------------------------------------------
module tb_quad_corner_offset;
    import qco_pkg::*;

    typedef struct {
        t_coord c [8];
        t_coord along;
        t_coord across;
        logic   inward;
    } t_quad_item;

    typedef struct {
        t_coord c [8];
        logic   degenerate;
    } t_moved_quad;

    typedef struct {
        t_quad_item item;
        bit         copy_back;
        logic       copy_flag;
    } t_table_row;

    localparam int WatchLimit = 20000;
    localparam int HoldCycles = 400;
    localparam int NumRandom  = 530;
    localparam int HorNbr [4] = '{1, 0, 3, 2};
    localparam int VerNbr [4] = '{2, 3, 0, 1};
    localparam string CoordName [8] = '{"new_top_left_x", "new_top_left_y",
        "new_top_right_x", "new_top_right_y", "new_bottom_left_x",
        "new_bottom_left_y", "new_bottom_right_x", "new_bottom_right_y"};

    logic   i_clk, i_rst_n, i_valid, o_ready, i_ready, o_valid;
    t_coord in_c [8];
    t_coord i_shift_along, i_shift_across;
    logic   i_inward;
    t_coord out_c [8];
    logic   o_degenerate;

    t_moved_quad moved_fifo [$];
    t_table_row  table_rows [$];
    int          errors;
    int          phase;
    int          quiet_cycles;
    bit          hold_req;
    int          hold_left;

    quad_corner_offset u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_top_left_x(in_c[0]), .i_top_left_y(in_c[1]),
        .i_top_right_x(in_c[2]), .i_top_right_y(in_c[3]),
        .i_bottom_left_x(in_c[4]), .i_bottom_left_y(in_c[5]),
        .i_bottom_right_x(in_c[6]), .i_bottom_right_y(in_c[7]),
        .i_shift_along(i_shift_along), .i_shift_across(i_shift_across),
        .i_inward(i_inward), .o_valid(o_valid), .i_ready(i_ready),
        .o_new_top_left_x(out_c[0]), .o_new_top_left_y(out_c[1]),
        .o_new_top_right_x(out_c[2]), .o_new_top_right_y(out_c[3]),
        .o_new_bottom_left_x(out_c[4]), .o_new_bottom_left_y(out_c[5]),
        .o_new_bottom_right_x(out_c[6]), .o_new_bottom_right_y(out_c[7]),
        .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic bit edge_unit(longint dx, longint dy, output longint ux,
                                     output longint uy);
        longint unsigned sq, len;
        ux = 0;
        uy = 0;
        sq = longint'(dx * dx + dy * dy);
        if (sq == 0) return 1'b0;
        len = int_sqrt(sq << 30);
        if (len == 0) return 1'b0;
        ux = (dx * (64'sd1 <<< 31)) / longint'(len);
        uy = (dy * (64'sd1 <<< 31)) / longint'(len);
        return 1'b1;
    endfunction

    function automatic t_coord clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_coord'(v);
    endfunction

    function automatic t_moved_quad offset_quad(t_quad_item q);
        t_moved_quad r;
        longint hux, huy, vux, vuy, px, py, tx, ty, sgn;
        bit ok;
        ok = 1'b1;
        sgn = q.inward ? 1 : -1;
        for (int k = 0; k < 4; k++) begin
            px = q.c[2*k];
            py = q.c[2*k+1];
            ok &= edge_unit(longint'(q.c[2*HorNbr[k]]) - px,
                            longint'(q.c[2*HorNbr[k]+1]) - py, hux, huy);
            ok &= edge_unit(longint'(q.c[2*VerNbr[k]]) - px,
                            longint'(q.c[2*VerNbr[k]+1]) - py, vux, vuy);
            tx = px * 65536 + sgn * (hux * longint'(q.along) + vux * longint'(q.across));
            ty = py * 65536 + sgn * (huy * longint'(q.along) + vuy * longint'(q.across));
            r.c[2*k]   = clamp16(tx / 65536);
            r.c[2*k+1] = clamp16(ty / 65536);
        end
        if (!ok) r.c = q.c;
        r.degenerate = !ok;
        return r;
    endfunction

    function automatic t_quad_item make_quad(int lx, int ly, int rx, int ry, int bx, int by,
                                             int brx, int bry, int sa, int sc, bit inw);
        t_quad_item q;
        q.c = '{t_coord'(lx), t_coord'(ly), t_coord'(rx), t_coord'(ry),
                t_coord'(bx), t_coord'(by), t_coord'(brx), t_coord'(bry)};
        q.along = t_coord'(sa);
        q.across = t_coord'(sc);
        q.inward = inw;
        return q;
    endfunction

    function automatic t_quad_item random_quad();
        t_quad_item q;
        int kind, x0, y0, w, h, mag;
        kind = $urandom_range(0, 99);
        mag = ($urandom_range(0, 3) == 0) ? 32767 : 200;
        x0 = $urandom_range(0, 20000) - 10000;
        y0 = $urandom_range(0, 20000) - 10000;
        w = $urandom_range(1, 3000);
        h = $urandom_range(1, 3000);
        q = make_quad(x0 + $urandom_range(0, 60) - 30, y0 + $urandom_range(0, 60) - 30,
                      x0 + w + $urandom_range(0, 60) - 30, y0 + $urandom_range(0, 60) - 30,
                      x0 + $urandom_range(0, 60) - 30, y0 + h + $urandom_range(0, 60) - 30,
                      x0 + w, y0 + h,
                      $urandom_range(0, 2 * mag) - mag, $urandom_range(0, 2 * mag) - mag,
                      1'($urandom_range(0, 1)));
        if (kind < 15) begin
            foreach (q.c[k]) q.c[k] = t_coord'($urandom());
            q.along = t_coord'($urandom());
            q.across = t_coord'($urandom());
        end else if (kind < 22) begin
            kind = $urandom_range(0, 3);
            q.c[2*HorNbr[kind]]   = q.c[2*kind];
            q.c[2*HorNbr[kind]+1] = q.c[2*kind+1];
        end
        return q;
    endfunction

    task automatic drive_quad(t_quad_item q);
        for (int k = 0; k < 8; k++) in_c[k] <= q.c[k];
        i_shift_along <= q.along;
        i_shift_across <= q.across;
        i_inward <= q.inward;
        i_valid <= 1'b1;
    endtask

    // Presents one item, waits for its acceptance, then maybe idles.
    task automatic send_quad(t_quad_item q);
        drive_quad(q);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (phase == 0 ? ($urandom_range(0, 99) < 10) :
            phase == 1 ? ($urandom_range(0, 99) < 72) : 1'b0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (moved_fifo.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= HoldCycles;
            i_ready <= 1'b0;
        end else begin
            i_ready <= phase == 0 ? ($urandom_range(0, 99) >= 72) :
                       phase == 1 ? ($urandom_range(0, 99) >= 10) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_quad_item  q;
        t_moved_quad want;
        bit          busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (i_valid && o_ready) begin
                busy = 1'b1;
                q.c = in_c;
                q.along = i_shift_along;
                q.across = i_shift_across;
                q.inward = i_inward;
                moved_fifo.push_back(offset_quad(q));
                if (table_rows.size() != 0 && table_rows[0].item.c == q.c
                    && table_rows[0].copy_back) begin
                    moved_fifo[$].c = q.c;
                    moved_fifo[$].degenerate = table_rows[0].copy_flag;
                end
                if (table_rows.size() != 0 && table_rows[0].item.c == q.c)
                    void'(table_rows.pop_front());
            end
            if (o_valid && i_ready) begin
                busy = 1'b1;
                if (moved_fifo.size() == 0) begin
                    $error("result item with no expectation");
                    errors++;
                end else begin
                    want = moved_fifo.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (out_c[k] !== want.c[k]) begin
                            $error("%s: expected %0d, actual %0d", CoordName[k],
                                   want.c[k], out_c[k]);
                            errors++;
                        end
                    end
                    if (o_degenerate !== want.degenerate) begin
                        $error("degenerate: expected %0d, actual %0d", want.degenerate,
                               o_degenerate);
                        errors++;
                    end
                end
            end
            quiet_cycles <= busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WatchLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_table_row row;
        t_table_row walk [$];
        errors = 0;
        phase = 0;
        quiet_cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        for (int k = 0; k < 8; k++) in_c[k] = '0;
        i_shift_along = '0;
        i_shift_across = '0;
        i_inward = 1'b0;

        // Rows marked copy_back carry an expectation that is read off directly.
        row.copy_back = 1'b1; row.copy_flag = 1'b0;
        row.item = make_quad(0, 0, 100, 0, 0, 100, 100, 100, 0, 0, 1); walk.push_back(row);
        row.copy_flag = 1'b1;
        row.item = make_quad(0, 0, 0, 0, 0, 0, 0, 0, 5, 5, 1); walk.push_back(row);
        row.item = make_quad(7, 7, 7, 7, 3, 90, 50, 90, -32768, 32767, 0); walk.push_back(row);
        row.item = make_quad(1, 1, 90, 1, 1, 80, 1, 80, 12, 12, 1); walk.push_back(row);
        row.item = make_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, 32767, 32767, 0); walk.push_back(row);
        row.copy_back = 1'b0;
        row.item = make_quad(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                             32767, 32767, 1); walk.push_back(row);
        row.item = make_quad(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                             32767, 32767, 0); walk.push_back(row);
        row.item = make_quad(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767,
                             -32768, -32768, 1); walk.push_back(row);
        row.item = make_quad(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768,
                             -32768, 32767, 0); walk.push_back(row);
        row.item = make_quad(0, 0, 100, 0, 0, 100, 100, 100, 10, 20, 1); walk.push_back(row);
        row.item = make_quad(0, 0, 100, 0, 0, 100, 100, 100, 10, 20, 0); walk.push_back(row);
        row.item = make_quad(-5, 3, 97, 11, -9, 120, 88, 131, -7, 3, 1); walk.push_back(row);
        row.item = make_quad(0, 0, 1, 0, 0, 1, 1, 1, 1, -1, 0); walk.push_back(row);
        row.item = make_quad(0, 0, 1, 1, 1, -1, 2, 0, 3, 3, 1); walk.push_back(row);
        row.item = make_quad(-100, -100, 32767, 5, 3, 32767, 32000, 32000, 32767, -32768,
                             0); walk.push_back(row);
        row.item = make_quad(-1, -1, -32768, 0, 0, -32768, -32768, -32768, -1, -1, 1);
        walk.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        table_rows = walk;
        foreach (walk[n]) send_quad(walk[n].item);
        drain_results();
        for (int n = 0; n < NumRandom; n++) begin
            if (n == NumRandom / 3 || n == 2 * NumRandom / 3) begin
                drain_results();
                phase++;
            end
            if (n == NumRandom / 6 || n == NumRandom - 60) hold_req = 1'b1;
            send_quad(random_quad());
        end
        drain_results();
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### quad_corner_offset.f
design/qco_pkg.sv
design/qco_unit_vec.sv
design/quad_corner_offset.sv
dv/tb_quad_corner_offset.sv
